FILE: rtl/core/olie_pkg.sv
`default_nettype none
package olie_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int POS_WIDTH   = 7;
   localparam int COUNT_WIDTH = 7;
   localparam int IDX_WIDTH   = 6;
   localparam int GROUP       = 8;
   localparam int GROUP_BITS  = 3;
   localparam int NUM_GROUPS  = CAPACITY / GROUP;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;
   localparam logic [1:0] OP_MODIFY = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [1:0]           func;
      logic [POS_WIDTH-1:0] position;
      logic signed [31:0]   value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [IDX_WIDTH-1:0]   found_index;
      logic [COUNT_WIDTH-1:0] count;
   } rsp_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                   advance;
      logic                   insert;
      logic                   erase;
      logic                   modify;
      logic                   find;
      logic [POS_WIDTH-1:0]   position;
      logic [COUNT_WIDTH-1:0] count;
      logic [DATA_WIDTH-1:0]  value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/core/olie_cell.sv
`default_nettype none
module olie_cell #(
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  olie_pkg::cell_ctrl_type        ctrl,
   input  logic [olie_pkg::DATA_WIDTH-1:0] left_entry,
   input  logic [olie_pkg::DATA_WIDTH-1:0] right_entry,
   output logic [olie_pkg::DATA_WIDTH-1:0] entry,
   output logic                           hit
);
   import olie_pkg::*;

   localparam logic [POS_WIDTH-1:0] MY_INDEX = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (MY_INDEX > ctrl.position) begin
            entry_in = left_entry;
         end else if (MY_INDEX == ctrl.position) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.erase) begin
         if (MY_INDEX >= ctrl.position) begin
            entry_in = right_entry;
         end
      end else if (ctrl.modify) begin
         if (MY_INDEX == ctrl.position) begin
            entry_in = ctrl.value;
         end
      end
   end

   assign hit_in = ctrl.find && (COUNT_WIDTH'(MY_INDEX) < ctrl.count)
                   && (entry_ff == ctrl.value);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.advance) begin
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule
`default_nettype wire

FILE: rtl/core/olie_pick.sv
`default_nettype none
module olie_pick #(
   parameter int WIDTH = 8
) (
   input  logic [WIDTH-1:0]         bits,
   output logic                     any,
   output logic [$clog2(WIDTH)-1:0] first
);
   always_comb begin
      first = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (bits[i]) begin
            first = ($clog2(WIDTH))'(i);
         end
      end
   end

   assign any = |bits;

endmodule
`default_nettype wire

FILE: rtl/core/ordered_list_insert_erase_core.sv
`default_nettype none
// channel  direction  signals                        payload
// req      in         req_valid, req_ready           req_data  (func, position, value)
// rsp      out        rsp_valid, rsp_ready           rsp_data  (status, found_index, count)
//
// One request per cycle while rsp is not held; rsp_valid rises after the s1, s2 and response registers.
// Cells update or compare at the request transfer; the first-match search
// is a two-level registered priority tree (8 groups of 8 cells).
// Synchronous reset clears the count and pipeline valids; entry contents
// are left as they are. A response held on rsp freezes the whole pipeline
// and drops req_ready.
module ordered_list_insert_erase_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  olie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olie_pkg::rsp_type rsp_data
);
   import olie_pkg::*;

   logic advance, accept;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   s1_valid_ff, s1_find_ff;
   logic [1:0]             s1_status_ff;
   logic [COUNT_WIDTH-1:0] s1_count_ff;
   logic [1:0]             status_in;

   logic                   s2_valid_ff, s2_find_ff;
   logic [1:0]             s2_status_ff;
   logic [COUNT_WIDTH-1:0] s2_count_ff;
   logic [NUM_GROUPS-1:0]  grp_any_ff, grp_any_in;
   logic [GROUP_BITS-1:0]  grp_idx_ff [NUM_GROUPS];
   logic [GROUP_BITS-1:0]  grp_idx_in [NUM_GROUPS];

   logic                   top_any;
   logic [GROUP_BITS-1:0]  top_grp;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] entry_q [CAPACITY];
   logic [CAPACITY-1:0]   hit_bits;

   logic pos_le, pos_lt, not_full;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   assign pos_le   = COUNT_WIDTH'(req_data.position) <= count_ff;
   assign pos_lt   = COUNT_WIDTH'(req_data.position) <  count_ff;
   assign not_full = count_ff < COUNT_WIDTH'(CAPACITY);

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      ctrl          = '0;
      ctrl.advance  = advance;
      ctrl.position = req_data.position;
      ctrl.count    = count_ff;
      ctrl.value    = req_data.value[DATA_WIDTH-1:0];
      if (accept) begin
         unique case (req_data.func)
            OP_INSERT: begin
               if (!pos_le) begin
                  status_in = ST_RANGE;
               end else if (!not_full) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + COUNT_WIDTH'(1);
               end
            end
            OP_ERASE: begin
               if (!pos_lt) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.erase = 1'b1;
                  count_in   = count_ff - COUNT_WIDTH'(1);
               end
            end
            OP_FIND: begin
               ctrl.find = 1'b1;
            end
            OP_MODIFY: begin
               if (!pos_lt) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.modify = 1'b1;
               end
            end
            default: begin
               status_in = ST_RANGE;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = req_data.value[DATA_WIDTH-1:0];
      end else begin : g_left
         assign left_w = entry_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = entry_q[i];
      end else begin : g_right
         assign right_w = entry_q[i+1];
      end
      olie_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_q[i]),
         .hit         (hit_bits[i])
      );
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      olie_pick #(.WIDTH(GROUP)) u_pick (
         .bits  (hit_bits[g*GROUP +: GROUP]),
         .any   (grp_any_in[g]),
         .first (grp_idx_in[g])
      );
   end

   olie_pick #(.WIDTH(NUM_GROUPS)) u_top_pick (
      .bits  (grp_any_ff),
      .any   (top_any),
      .first (top_grp)
   );

   always_comb begin
      rsp_in       = '0;
      rsp_in.count = s2_count_ff;
      if (s2_find_ff) begin
         if (top_any) begin
            rsp_in.status      = ST_OK;
            rsp_in.found_index = IDX_WIDTH'({top_grp, grp_idx_ff[top_grp]});
         end else begin
            rsp_in.status = ST_MISSING;
         end
      end else begin
         rsp_in.status = s2_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_find_ff   <= ctrl.find;
         s1_status_ff <= status_in;
         s1_count_ff  <= count_in;
         s2_find_ff   <= s1_find_ff;
         s2_status_ff <= s1_status_ff;
         s2_count_ff  <= s1_count_ff;
         grp_any_ff   <= grp_any_in;
         grp_idx_ff   <= grp_idx_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count changed without a request transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != ST_OK) |-> rsp_ff.found_index == '0)
      else $error("found_index set on a failed response");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top;
   import olie_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_responses[$];

   logic signed [DATA_WIDTH-1:0] list_words[CAPACITY];
   int list_len = 0;

   logic signed [31:0] value_pool[16];
   int gen_count = 0;

   int mismatches = 0;
   int cycles = 0;
   int send_gap = 0;
   int send_quiet = 0;
   int recv_stall = 0;
   int recv_quiet = 0;

   ordered_list_insert_erase_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // most gaps short, a few long, occasional stretches with none
   function automatic int idle_length(inout int quiet_left);
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet_left = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rsp_type list_apply(input req_type r);
      rsp_type res;
      int i;
      res = '0;
      res.status = ST_OK;
      case (r.func)
         OP_INSERT: begin
            if (r.position > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = list_len; i > r.position; i--) list_words[i] = list_words[i-1];
               list_words[r.position] = r.value;
               list_len++;
            end
         end
         OP_ERASE: begin
            if (r.position >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (i = r.position; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         OP_FIND: begin
            res.status = ST_MISSING;
            for (i = 0; i < list_len; i++) begin
               if (res.status == ST_MISSING && list_words[i] == r.value) begin
                  res.status = ST_OK;
                  res.found_index = i[IDX_WIDTH-1:0];
               end
            end
         end
         default: begin
            if (r.position >= list_len) res.status = ST_RANGE;
            else list_words[r.position] = r.value;
         end
      endcase
      res.count = list_len[COUNT_WIDTH-1:0];
      return res;
   endfunction

   task automatic add_request(input logic [1:0] func, input int position,
                              input logic signed [31:0] value);
      req_type r;
      r.func = func;
      r.position = position[POS_WIDTH-1:0];
      r.value = value;
      pending_requests.push_back(r);
      if (func == OP_INSERT && r.position <= gen_count && gen_count < CAPACITY) gen_count++;
      if (func == OP_ERASE && r.position < gen_count) gen_count--;
   endtask

   // mode 0 grows the list, 1 shrinks it, 2 mixes
   task automatic add_random_request(input int mode);
      int r;
      int position;
      logic [1:0] func;
      logic signed [31:0] value;
      r = $urandom_range(0, 99);
      case (mode)
         0: func = (r < 65) ? OP_INSERT : (r < 75) ? OP_ERASE : (r < 90) ? OP_FIND : OP_MODIFY;
         1: func = (r < 10) ? OP_INSERT : (r < 75) ? OP_ERASE : (r < 90) ? OP_FIND : OP_MODIFY;
         default: func = (r < 30) ? OP_INSERT : (r < 60) ? OP_ERASE : (r < 80) ? OP_FIND : OP_MODIFY;
      endcase
      r = $urandom_range(0, 99);
      if (r < 10 || func == OP_FIND) begin
         position = $urandom_range(0, 127);
      end else if (func == OP_INSERT) begin
         if (r < 22) position = 0;
         else if (r < 34) position = gen_count;
         else position = $urandom_range(0, gen_count);
      end else if (gen_count == 0) begin
         position = 0;
      end else begin
         if (r < 22) position = 0;
         else if (r < 34) position = gen_count - 1;
         else position = $urandom_range(0, gen_count - 1);
      end
      if ($urandom_range(0, 1) == 0) value = value_pool[$urandom_range(0, 15)];
      else value = $urandom;
      add_request(func, position, value);
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_responses.push_back(list_apply(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_length(send_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer %p", rsp_data));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.found_index !== want.found_index)
                  report_mismatch($sformatf("found_index %0d, expected %0d",
                                            rsp_data.found_index, want.found_index));
               if (rsp_data.count !== want.count)
                  report_mismatch($sformatf("count %0d, expected %0d",
                                            rsp_data.count, want.count));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_stall = idle_length(recv_quiet);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int i;
      int mode;
      int segment;
      value_pool[0] = 32'sh0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'sh7FFFFFFF;
      value_pool[3] = 32'sh80000000;
      for (i = 4; i < 16; i++) value_pool[i] = $urandom;

      // empty list corner cases
      add_request(OP_FIND, 0, 32'sh0);
      add_request(OP_ERASE, 0, 32'sh0);
      add_request(OP_MODIFY, 0, 32'sh1);
      add_request(OP_INSERT, 1, 32'sh2);
      add_request(OP_INSERT, 127, 32'sh3);
      // pushes front and back, duplicate value
      add_request(OP_INSERT, 0, 32'sh7FFFFFFF);
      add_request(OP_INSERT, 0, 32'sh80000000);
      add_request(OP_INSERT, 2, 32'sh0);
      add_request(OP_INSERT, 3, -32'sd1);
      add_request(OP_INSERT, 1, 32'sh0);
      add_request(OP_INSERT, 6, 32'sh4);
      add_request(OP_FIND, 127, 32'sh0);
      add_request(OP_FIND, 0, -32'sd1);
      add_request(OP_FIND, 5, 32'sh80000000);
      add_request(OP_FIND, 0, 32'sh12345);
      add_request(OP_MODIFY, 4, 32'sh5);
      add_request(OP_MODIFY, 5, 32'sh6);
      add_request(OP_MODIFY, 127, 32'sh7);
      add_request(OP_ERASE, 5, 32'sh0);
      add_request(OP_ERASE, 127, 32'sh0);
      add_request(OP_ERASE, 4, 32'sh0);
      add_request(OP_ERASE, 0, 32'sh0);
      add_request(OP_FIND, 0, 32'sh7FFFFFFF);

      i = 0;
      while (i < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         segment = $urandom_range(60, 200);
         if (segment > RANDOM_ITEMS - i) segment = RANDOM_ITEMS - i;
         repeat (segment) begin
            add_random_request(mode);
            i++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/olie_pkg.sv
rtl/core/olie_cell.sv
rtl/core/olie_pick.sv
rtl/core/ordered_list_insert_erase_core.sv
test/tb_top.sv
